// File: hdl/tag_table_scan_engine_top_defines.svh
// Assertion macros shared by the tag table scan engine.
`ifndef TAG_TABLE_SCAN_ENGINE_TOP_DEFINES_SVH
`define TAG_TABLE_SCAN_ENGINE_TOP_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define TTS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tag table check failed");

// Consequent must hold in the same cycle as the antecedent.
`define TTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tag table check failed");

`endif

// File: hdl/tts_pkg.sv
// Types, codes and image constants of the tag table scan engine.
package tts_pkg;

    localparam int unsigned ACT_W      = 2;
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = 3;

    localparam logic [ACT_W-1:0] ACT_RELOAD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ACCESS = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESP   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SCAN   = 2'd3;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_POLL  = 1'b1;

    localparam logic IMG_MASTER = 1'b0;
    localparam logic IMG_SLAVE  = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_STATUS_TAG    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_EMPTY_VALUE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MISSING_VALUE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MASTER_STATUS = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SLAVE_STATUS  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INITIAL_IMAGE = 3'd5;

    localparam logic [7:0] POLL_TAG_BASE = 8'd80;
    localparam logic [7:0] POLL_DEVICE   = 8'd8;
    localparam logic [1:0] POLL_POINTS   = 2'd3;

    localparam int unsigned IMG_MASTER_SIZE = 4;
    localparam int unsigned IMG_SLAVE_SIZE  = 1;

    typedef struct packed {
        logic [7:0]         status_tag;
        logic signed [15:0] empty_value;
        logic signed [15:0] missing_value;
        logic signed [15:0] master_status;
        logic signed [15:0] slave_status;
        logic               initial_image;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        status_tag:    8'd255,
        empty_value:   -16'sd1,
        missing_value: -16'sd2,
        master_status: 16'sd0,
        slave_status:  16'sd3,
        initial_image: IMG_MASTER
    };

    typedef struct packed {
        logic [7:0]         tag;
        logic [7:0]         device;
        logic [7:0]         address;
        logic signed [15:0] value;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic               image_select;
        logic [7:0]         tag;
        logic               is_write;
        logic [7:0]         device;
        logic [7:0]         address;
        logic signed [15:0] value;
    } t_req;

    typedef struct packed {
        logic               kind;
        logic [7:0]         reply_tag;
        logic signed [15:0] reply_value;
        logic [7:0]         poll_device;
        logic [7:0]         poll_address;
    } t_rsp;

    // Entry k of the master or slave image.
    function automatic t_entry image_entry(input logic slave, input logic [1:0] k,
                                           input t_cfg c);
        t_entry e;
        e.tag     = c.status_tag;
        e.device  = 8'd0;
        e.address = 8'd0;
        e.value   = slave ? c.slave_status : c.master_status;
        if (!slave && (k != POLL_POINTS)) begin
            e.tag     = POLL_TAG_BASE + {6'd0, k};
            e.device  = POLL_DEVICE;
            e.address = POLL_TAG_BASE + {6'd0, k};
            e.value   = c.empty_value;
        end
        return e;
    endfunction

endpackage

// File: hdl/tts_if.sv
// Request and response channel interfaces of the tag table scan engine.
interface tts_req_if import tts_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic               image_select;
    logic [7:0]         tag;
    logic               is_write;
    logic [7:0]         device;
    logic [7:0]         address;
    logic signed [15:0] value;

    modport source (output valid, action, image_select, tag, is_write, device, address,
                    value, input ready);
    modport sink (input valid, action, image_select, tag, is_write, device, address,
                  value, output ready);
endinterface

interface tts_rsp_if import tts_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [7:0]         reply_tag;
    logic signed [15:0] reply_value;
    logic [7:0]         poll_device;
    logic [7:0]         poll_address;

    modport source (output valid, kind, reply_tag, reply_value, poll_device, poll_address,
                    input ready);
    modport sink (input valid, kind, reply_tag, reply_value, poll_device, poll_address,
                  output ready);
endinterface

// File: hdl/tts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tts_ram #(
    parameter int unsigned WIDTH = 40,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/tts_cfg.sv
// APB register bank of the tag table scan engine.
module tts_cfg import tts_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);
    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_STATUS_TAG:    r_cfg.status_tag    <= pwdata[7:0];
                REG_EMPTY_VALUE:   r_cfg.empty_value   <= pwdata[15:0];
                REG_MISSING_VALUE: r_cfg.missing_value <= pwdata[15:0];
                REG_MASTER_STATUS: r_cfg.master_status <= pwdata[15:0];
                REG_SLAVE_STATUS:  r_cfg.slave_status  <= pwdata[15:0];
                REG_INITIAL_IMAGE: r_cfg.initial_image <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_STATUS_TAG:    prdata = {24'd0, r_cfg.status_tag};
            REG_EMPTY_VALUE:   prdata = {16'd0, r_cfg.empty_value};
            REG_MISSING_VALUE: prdata = {16'd0, r_cfg.missing_value};
            REG_MASTER_STATUS: prdata = {16'd0, r_cfg.master_status};
            REG_SLAVE_STATUS:  prdata = {16'd0, r_cfg.slave_status};
            REG_INITIAL_IMAGE: prdata = {31'd0, r_cfg.initial_image};
            default:           prdata = '0;
        endcase
    end
endmodule

// File: hdl/tag_table_scan_engine_top.sv
// Tag table scan engine: request channel in, reply/poll channel out, APB registers.
//
// Requests arrive on i_req (valid/ready); replies and poll requests leave on o_rsp.
// One request is worked at a time; i_req.ready is high only while the sequencer idles.
// The table sits in one RAM with a registered read; a single comparator walks it,
// entry by entry: read, then compare and optional write back.
// With n table entries in use (1 or 4): a reload writes the selected image,
// access and response walk up to n entries, and a read access posts a reply;
// a scan tick reads one entry and posts a poll unless it is the status entry.
// A result sits in an output register; the next request is taken while it waits.
// When o_rsp stalls and a second result is ready, the sequencer holds until the
// output register frees up.
// After reset the block writes the master image with reset register values,
// holding i_req.ready low meanwhile; APB writes are taken throughout.
// Registers live at byte address 4*i, written in the APB access cycle.
module tag_table_scan_engine_top import tts_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tts_req_if.sink               i_req,
    tts_rsp_if.source             o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    `include "tag_table_scan_engine_top_defines.svh"

    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_POST = 3'd4;

    t_cfg w_cfg;
    t_cfg w_load_cfg;

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_ptr, n_ptr;
    logic [IW-1:0] r_scan, n_scan;
    logic [CW-1:0] r_count, n_count;
    logic          r_img, n_img;
    logic          r_boot, n_boot;
    t_req          r_item, n_item;
    t_rsp          r_res, n_res;
    logic          r_out_valid, n_out_valid;
    t_rsp          r_out, n_out;

    logic          w_we;
    t_entry        w_wdata;
    logic [IW-1:0] w_raddr;
    t_entry        w_rdata;
    logic          w_last;
    logic          w_load_last;
    logic [CW-1:0] w_scan_inc;
    logic [IW-1:0] w_scan_next;
    logic          w_in_acc;
    logic          w_out_acc;

    tts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_ptr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_acc    = i_req.valid & i_req.ready;
    assign w_out_acc   = o_rsp.valid & o_rsp.ready;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.kind         = r_out.kind;
    assign o_rsp.reply_tag    = r_out.reply_tag;
    assign o_rsp.reply_value  = r_out.reply_value;
    assign o_rsp.poll_device  = r_out.poll_device;
    assign o_rsp.poll_address = r_out.poll_address;

    // Boot load uses reset values so early APB writes cannot leak into it.
    assign w_load_cfg  = r_boot ? CFG_RESET : w_cfg;
    assign w_last      = (CW'(r_ptr) == (r_count - CW'(1)));
    assign w_load_last = r_img ? (r_ptr[1:0] == 2'd0) : (r_ptr[1:0] == POLL_POINTS);
    assign w_scan_inc  = CW'(r_scan) + CW'(1);
    assign w_scan_next = (w_scan_inc >= r_count) ? '0 : w_scan_inc[IW-1:0];
    assign w_raddr     = r_ptr;

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_scan      = r_scan;
        n_count     = r_count;
        n_img       = r_img;
        n_boot      = r_boot;
        n_item      = r_item;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_we        = 1'b0;
        w_wdata     = w_rdata;

        if (w_out_acc) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_LOAD: begin
                w_we    = 1'b1;
                w_wdata = image_entry(r_img, r_ptr[1:0], w_load_cfg);
                n_ptr   = r_ptr + IW'(1);
                if (w_load_last) begin
                    n_count = r_img ? CW'(IMG_SLAVE_SIZE) : CW'(IMG_MASTER_SIZE);
                    n_scan  = '0;
                    n_boot  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_item.action       = i_req.action;
                    n_item.image_select = i_req.image_select;
                    n_item.tag          = i_req.tag;
                    n_item.is_write     = i_req.is_write;
                    n_item.device       = i_req.device;
                    n_item.address      = i_req.address;
                    n_item.value        = i_req.value;
                    n_ptr               = '0;
                    unique case (i_req.action)
                        ACT_RELOAD: begin
                            n_img   = i_req.image_select;
                            n_state = S_LOAD;
                        end
                        ACT_ACCESS, ACT_RESP: n_state = S_RD;
                        ACT_SCAN: begin
                            n_scan  = w_scan_next;
                            n_ptr   = w_scan_next;
                            n_state = S_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                n_res = '0;
                unique case (r_item.action)
                    ACT_ACCESS: begin
                        if (w_rdata.tag == r_item.tag && !r_item.is_write) begin
                            n_res.kind        = KIND_REPLY;
                            n_res.reply_tag   = r_item.tag;
                            n_res.reply_value = w_rdata.value;
                            n_state           = S_POST;
                        end else begin
                            if (w_rdata.tag == r_item.tag) begin
                                w_we          = 1'b1;
                                w_wdata.value = r_item.value;
                            end
                            if (w_last) begin
                                if (r_item.is_write) begin
                                    n_state = S_IDLE;
                                end else begin
                                    n_res.kind        = KIND_REPLY;
                                    n_res.reply_tag   = r_item.tag;
                                    n_res.reply_value = w_cfg.missing_value;
                                    n_state           = S_POST;
                                end
                            end else begin
                                n_ptr   = r_ptr + IW'(1);
                                n_state = S_RD;
                            end
                        end
                    end
                    ACT_RESP: begin
                        if (w_rdata.device == r_item.device &&
                            w_rdata.address == r_item.address &&
                            w_rdata.tag != w_cfg.status_tag) begin
                            w_we          = 1'b1;
                            w_wdata.value = r_item.value;
                        end
                        if (w_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_ptr   = r_ptr + IW'(1);
                            n_state = S_RD;
                        end
                    end
                    ACT_SCAN: begin
                        // Skip the status entry; the index has already moved.
                        if (w_rdata.tag != w_cfg.status_tag) begin
                            n_res.kind         = KIND_POLL;
                            n_res.poll_device  = w_rdata.device;
                            n_res.poll_address = w_rdata.address;
                            n_state            = S_POST;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_POST: begin
                // Hold until the output register is free or drains this cycle.
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_ptr       <= '0;
            r_scan      <= '0;
            r_count     <= CW'(IMG_MASTER_SIZE);
            r_img       <= IMG_MASTER;
            r_boot      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_scan      <= n_scan;
            r_count     <= n_count;
            r_img       <= n_img;
            r_boot      <= n_boot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    `TTS_ASSERT_ALWAYS(a_count_image, i_clk, i_rst_n,
        r_count == CW'(IMG_MASTER_SIZE) || r_count == CW'(IMG_SLAVE_SIZE))
    `TTS_ASSERT_ALWAYS(a_scan_in_range, i_clk, i_rst_n, CW'(r_scan) < r_count)
    `TTS_ASSERT_IMP(a_walk_in_range, i_clk, i_rst_n,
        r_state == S_RD || r_state == S_CMP, CW'(r_ptr) < r_count)
endmodule
